[hdl/dcc_pkg.sv]
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared widths, base codes and controller/datapath command types for the
// DNA consensus counter.
// ----------------------------------------------------------------------------
package dcc_pkg;

  // Field widths of the transactions and the configuration register.
  localparam int CFG_W   = 11;
  localparam int FUNC_W  = 1;
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 3;
  localparam int MIS_W   = 7;
  localparam int TOT_W   = 17;

  // Column storage: four saturating base counters per column.
  localparam int CNT_W   = 7;
  localparam int NBASES  = 4;
  localparam int ROW_W   = NBASES * CNT_W;
  localparam int SUM_W   = CNT_W + 2;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [MIS_W-1:0] MIS_MAX = {MIS_W{1'b1}};
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  // Default depth of the column store.
  localparam int DEF_MAX_COLUMNS = 1024;

  // Function codes of an input transaction.
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_EMIT = 1'b1;

  // Accepted base characters.
  localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_C = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_G = 8'h47;
  localparam logic [BYTE_W-1:0] CHAR_T = 8'h54;

  // Consensus codes.
  localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // write one zero row of the clearing sweep
    logic accept;    // capture a transaction and start the row read
    logic load_wb;   // write back the incremented row of a load
    logic eval;      // register consensus and column sum of an emit
    logic finish;    // complete an emit: clear row, post the result
  } dcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;  // the clearing sweep is at its last row
    logic func_emit; // the captured transaction is an emit
    logic out_free;  // the result register can take a new result
  } dcc_sts_t;

  // Counter lane of a base character; valid is low for any other byte.
  function automatic logic [2:0] base_lane(input logic [BYTE_W-1:0] b);
    logic [2:0] r;
    r = 3'b000;
    unique case (b)
      CHAR_A:  r = 3'b100;
      CHAR_C:  r = 3'b101;
      CHAR_G:  r = 3'b110;
      CHAR_T:  r = 3'b111;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

[hdl/dcc_in_if.sv]
// ----------------------------------------------------------------------------
// dcc_in_if
// Input channel: valid/ready handshake with a function code and a base byte.
// ----------------------------------------------------------------------------
interface dcc_in_if;
  logic                         valid;
  logic                         ready;
  logic [dcc_pkg::FUNC_W-1:0]   func;
  logic [dcc_pkg::BYTE_W-1:0]   base_byte;

  modport source (output valid, output func, output base_byte, input ready);
  modport sink   (input valid, input func, input base_byte, output ready);
endinterface

[hdl/dcc_out_if.sv]
// ----------------------------------------------------------------------------
// dcc_out_if
// Result channel: valid/ready handshake with one consensus column result.
// ----------------------------------------------------------------------------
interface dcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [dcc_pkg::CODE_W-1:0]   consensus_code;
  logic [dcc_pkg::MIS_W-1:0]    column_mismatches;
  logic [dcc_pkg::TOT_W-1:0]    total_distance;
  logic                         last_column;

  modport source (output valid, output consensus_code, output column_mismatches,
                  output total_distance, output last_column, input ready);
  modport sink   (input valid, input consensus_code, input column_mismatches,
                  input total_distance, input last_column, output ready);
endinterface

[hdl/dcc_ctrl.sv]
// ----------------------------------------------------------------------------
// dcc_ctrl
// Controller: sequences the clearing sweep and the read, evaluate and
// write-back steps of each transaction.
// ----------------------------------------------------------------------------
module dcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dcc_pkg::dcc_sts_t sts,
  output dcc_pkg::dcc_cmd_t cmd
);
  import dcc_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   accept;

  assign accept   = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  // Command decode from the current state.
  always_comb begin
    cmd         = '0;
    cmd.clear   = (state_r == S_CLEAR);
    cmd.accept  = accept;
    cmd.load_wb = (state_r == S_EVAL) && !sts.func_emit;
    cmd.eval    = (state_r == S_EVAL) && sts.func_emit;
    cmd.finish  = (state_r == S_FINISH) && sts.out_free;
  end

  // State register and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_ready_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (sts.clr_done) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r    <= S_EVAL;
            in_ready_r <= 1'b0;
          end
        end
        S_EVAL: begin
          if (sts.func_emit) begin
            state_r <= S_FINISH;
          end else begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        S_FINISH: begin
          if (sts.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_CLEAR;
          in_ready_r <= 1'b0;
        end
      endcase
    end
  end

  // A transaction is taken only in the idle state and moves on to evaluation.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == S_IDLE)
    else $error("transaction accepted outside the idle state");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EVAL && !in_ready_r)
    else $error("accepted transaction did not enter evaluation");

  // Ready stays low for the whole clearing sweep.
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready_r)
    else $error("ready raised during the clearing sweep");

endmodule

[hdl/dcc_datapath.sv]
// ----------------------------------------------------------------------------
// dcc_datapath
// Datapath: column counter memory, load/emit positions, consensus and
// mismatch evaluation, running distance and the result register.
// ----------------------------------------------------------------------------
module dcc_datapath #(
  parameter int MAX_COLUMNS = dcc_pkg::DEF_MAX_COLUMNS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dcc_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [dcc_pkg::FUNC_W-1:0]  in_func,
  input  logic [dcc_pkg::BYTE_W-1:0]  in_base_byte,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [dcc_pkg::CODE_W-1:0]  out_consensus_code,
  output logic [dcc_pkg::MIS_W-1:0]   out_column_mismatches,
  output logic [dcc_pkg::TOT_W-1:0]   out_total_distance,
  output logic                        out_last_column,
  input  dcc_pkg::dcc_cmd_t           cmd,
  output dcc_pkg::dcc_sts_t           sts
);
  import dcc_pkg::*;

  localparam int AW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int MCW  = $clog2(MAX_COLUMNS + 1);
  localparam int CW   = (MCW > CFG_W) ? MCW : CFG_W;
  localparam logic [CW-1:0] COLS_MAX = CW'(MAX_COLUMNS);
  localparam logic [AW-1:0] LAST_ROW = AW'(MAX_COLUMNS - 1);

  logic [ROW_W-1:0]  mem [MAX_COLUMNS];

  logic [CW-1:0]     cols_r;
  logic [CW-1:0]     cfg_ext;
  logic [AW-1:0]     load_pos_r;
  logic [AW-1:0]     emit_pos_r;
  logic [AW-1:0]     clr_addr_r;
  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     eff_load;
  logic [AW-1:0]     eff_emit;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     addr_inc;
  logic              addr_wrap;
  logic [TOT_W-1:0]  dist_r;
  logic              func_emit_r;
  logic [BYTE_W-1:0] byte_r;
  logic [ROW_W-1:0]  rd_data_r;

  logic              we;
  logic [AW-1:0]     wr_addr;
  logic [ROW_W-1:0]  wr_data;
  logic [ROW_W-1:0]  inc_row;
  logic [2:0]        lane;

  logic [CNT_W-1:0]  best_nxt;
  logic [CODE_W-1:0] code_nxt;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  best_r;
  logic [CODE_W-1:0] code_r;
  logic [SUM_W-1:0]  sum_r;

  logic [SUM_W-1:0]  others;
  logic [MIS_W-1:0]  mis_sat;
  logic [TOT_W:0]    tot_sum;
  logic [TOT_W-1:0]  tot_sat;

  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic [MIS_W-1:0]  out_mis_r;
  logic [TOT_W-1:0]  out_tot_r;
  logic              out_last_r;

  // Effective column count: zero acts as one, large values clip to the depth.
  assign cfg_ext = CW'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CW'(1);
    end else if (cfg_we) begin
      priority if (cfg_ext == '0) begin
        cols_r <= CW'(1);
      end else if (cfg_ext > COLS_MAX) begin
        cols_r <= COLS_MAX;
      end else begin
        cols_r <= cfg_ext;
      end
    end
  end

  // Positions at or past the column count are taken as column zero.
  assign eff_load  = (CW'(load_pos_r) >= cols_r) ? '0 : load_pos_r;
  assign eff_emit  = (CW'(emit_pos_r) >= cols_r) ? '0 : emit_pos_r;
  assign rd_addr   = (in_func == FUNC_EMIT) ? eff_emit : eff_load;
  assign addr_wrap = (CW'(addr_r) + CW'(1)) >= cols_r;
  assign addr_inc  = addr_wrap ? '0 : addr_r + AW'(1);

  // Load: bump the counter of the matching base unless it is full.
  assign lane = base_lane(byte_r);

  always_comb begin
    inc_row = rd_data_r;
    if (lane[2] && rd_data_r[lane[1:0]*CNT_W +: CNT_W] != CNT_MAX) begin
      inc_row[lane[1:0]*CNT_W +: CNT_W] = rd_data_r[lane[1:0]*CNT_W +: CNT_W] + CNT_W'(1);
    end
  end

  // Single write port shared by the sweep, load write-back and emit clear.
  always_comb begin
    we      = cmd.clear || cmd.load_wb || cmd.finish;
    wr_addr = cmd.clear ? clr_addr_r : addr_r;
    wr_data = cmd.load_wb ? inc_row : '0;
  end

  // Column memory with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.accept) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear && clr_addr_r != LAST_ROW) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Capture of an accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_emit_r <= 1'b0;
    end else if (cmd.accept) begin
      func_emit_r <= (in_func == FUNC_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_base_byte;
      addr_r <= rd_addr;
    end
  end

  // Consensus: first strictly larger count wins, so ties go to the earlier base.
  always_comb begin
    best_nxt = '0;
    code_nxt = CODE_NONE;
    sum_nxt  = '0;
    for (int j = 0; j < NBASES; j++) begin
      if (rd_data_r[j*CNT_W +: CNT_W] > best_nxt) begin
        best_nxt = rd_data_r[j*CNT_W +: CNT_W];
        code_nxt = CODE_W'(j + 1);
      end
      sum_nxt = sum_nxt + SUM_W'(rd_data_r[j*CNT_W +: CNT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      best_r <= best_nxt;
      code_r <= code_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Mismatches are the column total minus the winning count, both saturated.
  assign others  = sum_r - SUM_W'(best_r);
  assign mis_sat = (others > SUM_W'(MIS_MAX)) ? MIS_MAX : others[MIS_W-1:0];
  assign tot_sum = {1'b0, dist_r} + (TOT_W + 1)'(mis_sat);
  assign tot_sat = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];

  // Positions and running distance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
      emit_pos_r <= '0;
      dist_r     <= '0;
    end else if (cmd.load_wb) begin
      load_pos_r <= addr_inc;
    end else if (cmd.finish) begin
      if (addr_wrap) begin
        load_pos_r <= '0;
        emit_pos_r <= '0;
        dist_r     <= '0;
      end else begin
        emit_pos_r <= addr_inc;
        dist_r     <= tot_sat;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_code_r <= code_r;
      out_mis_r  <= mis_sat;
      out_tot_r  <= tot_sat;
      out_last_r <= addr_wrap;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_consensus_code    = out_code_r;
  assign out_column_mismatches = out_mis_r;
  assign out_total_distance    = out_tot_r;
  assign out_last_column       = out_last_r;

  assign sts.clr_done  = (clr_addr_r == LAST_ROW);
  assign sts.func_emit = func_emit_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  // An empty column reports no mismatches.
  a_empty_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_code_r == CODE_NONE |-> out_mis_r == '0)
    else $error("empty column reported mismatches");

  // The running total always covers the mismatches of its own column.
  a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_tot_r >= TOT_W'(out_mis_r))
    else $error("total distance below column mismatches");

  // The final column returns positions and distance to zero.
  a_case_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && addr_wrap |=> emit_pos_r == '0 && load_pos_r == '0 && dist_r == '0)
    else $error("state not reset after the last column");

endmodule

[hdl/dna_consensus_counter.sv]
// ----------------------------------------------------------------------------
// dna_consensus_counter
// Per-column A/C/G/T counting of aligned sequences with consensus and
// Hamming distance readout.
//
//   Channel  Direction  Handshake          Payload
//   in_ch    input      valid/ready        func, base_byte
//   out_ch   output     valid/ready        consensus_code, column_mismatches,
//                                          total_distance, last_column
//   cfg_*    input      write enable only  column_count
//
// A load transaction passes through the evaluation state and an emit through
// the evaluation and finish states from acceptance until ready returns; both
// follow the registered read and the write-back of the column memory's single write port.
// After reset a clearing sweep zeroes all MAX_COLUMNS rows of the column memory
// (1024 by default) with ready held low; configuration writes are taken.
// A result waits in the output register; an emit whose result register is
// still full holds in its last step until the result is taken.
// ----------------------------------------------------------------------------
module dna_consensus_counter #(
  parameter int MAX_COLUMNS = dcc_pkg::DEF_MAX_COLUMNS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [dcc_pkg::CFG_W-1:0] cfg_wdata,
  dcc_in_if.sink                    in_ch,
  dcc_out_if.source                 out_ch
);
  import dcc_pkg::*;

  dcc_cmd_t cmd;
  dcc_sts_t sts;

  // Sequencing of the clearing sweep and of each transaction.
  dcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Column store, evaluation and result register.
  dcc_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_func               (in_ch.func),
    .in_base_byte          (in_ch.base_byte),
    .out_ready             (out_ch.ready),
    .out_valid             (out_ch.valid),
    .out_consensus_code    (out_ch.consensus_code),
    .out_column_mismatches (out_ch.column_mismatches),
    .out_total_distance    (out_ch.total_distance),
    .out_last_column       (out_ch.last_column),
    .cmd                   (cmd),
    .sts                   (sts)
  );

endmodule
